@@ hw/rtl/qeap_pkg.sv @@
// Shared types and constants for the quarter ellipse arc point generator.
// Used by the front, back and top level; depends on nothing.
package qeap_pkg;

    localparam int COORD_W = 31;
    localparam int FRAC_W  = 30;

    typedef enum logic [1:0] {
        KIND_LINE     = 2'd0,
        KIND_CW       = 2'd1,
        KIND_CCW      = 2'd2,
        KIND_LINE_ALT = 2'd3
    } kind_t;

    // Divisors of the sine and cosine series terms, one per term after the first.
    localparam logic [63:0] SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210, 64'd272};
    localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182, 64'd240};

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q_ONE       = 64'd1073741824;

    // One classified segment, as handed from the front to the back.
    typedef struct packed {
        logic                        arc;
        logic signed [COORD_W-1:0]   xs;
        logic signed [COORD_W-1:0]   ys;
        logic signed [COORD_W-1:0]   xe;
        logic signed [COORD_W-1:0]   ye;
        logic signed [COORD_W-1:0]   xo;
        logic signed [COORD_W-1:0]   yo;
        logic        [COORD_W-1:0]   a_mag;
        logic                        a_neg;
        logic        [COORD_W-1:0]   r_mag;
        logic                        s_neg;
        logic                        swap;
    } desc_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic                        last;
    } point_t;

endpackage

@@ hw/rtl/qeap_fifo.sv @@
// Small first-in first-out queue built from registers.
// Generic over width and power-of-two depth; no package dependency.
module qeap_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + PW'(1) : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + PW'(1) : rptr_reg;
        count_next = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/qeap_front.sv @@
// Front end: classifies a segment and works out the arc center, radii and signs.
// Depends on qeap_pkg for the descriptor and kind codes.
module qeap_front (
    input  logic signed [qeap_pkg::COORD_W-1:0] x_start,
    input  logic signed [qeap_pkg::COORD_W-1:0] y_start,
    input  logic signed [qeap_pkg::COORD_W-1:0] x_end,
    input  logic signed [qeap_pkg::COORD_W-1:0] y_end,
    input  logic        [1:0]                   func,
    output qeap_pkg::desc_t                     desc
);

    localparam int W = qeap_pkg::COORD_W;

    qeap_pkg::kind_t     kind;
    logic                ccw;
    logic                cw;
    logic signed [W-1:0] xa, ya, xb, yb;
    logic signed [W-1:0] xo, yo;
    logic signed [W:0]   dx, dy, u, v, a;
    logic        [W:0]   rx, ry, a_abs;

    always_comb
    begin
        kind = qeap_pkg::kind_t'(func);
        ccw  = 1'b0;
        cw   = 1'b0;
        unique case (kind)
            qeap_pkg::KIND_CW:  cw  = 1'b1;
            qeap_pkg::KIND_CCW: ccw = 1'b1;
            default:            ;
        endcase

        // The counterclockwise case swaps the endpoints for choosing the center only.
        xa = ccw ? x_end   : x_start;
        ya = ccw ? y_end   : y_start;
        xb = ccw ? x_start : x_end;
        yb = ccw ? y_start : y_end;

        if ((xb > xa) == (yb > ya))
        begin
            xo = xb;
            yo = ya;
        end
        else
        begin
            xo = xa;
            yo = yb;
        end

        dx = (W+1)'(xa) - (W+1)'(xb);
        dy = (W+1)'(ya) - (W+1)'(yb);
        rx = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
        ry = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
        u  = (W+1)'(x_start) - (W+1)'(xo);
        v  = (W+1)'(y_start) - (W+1)'(yo);

        desc.swap  = (v != '0);
        a          = desc.swap ? v : u;
        a_abs      = a[W] ? (W+1)'(-a) : (W+1)'(a);
        desc.a_mag = a_abs[W-1:0];
        desc.a_neg = a[W];
        desc.r_mag = desc.swap ? rx[W-1:0] : ry[W-1:0];
        desc.s_neg = desc.swap ? !(cw ^ v[W]) : (cw ^ u[W]);

        desc.arc = (cw || ccw) && (x_start != x_end) && (y_start != y_end);
        desc.xs  = x_start;
        desc.ys  = y_start;
        desc.xe  = x_end;
        desc.ye  = y_end;
        desc.xo  = xo;
        desc.yo  = yo;
    end

endmodule

@@ hw/rtl/qeap_back.sv @@
// Back end: walks the points of one segment, scaling the radii by cos and sin.
// Depends on qeap_pkg; the cos/sin table is built at elaboration from SEGMENTS.
module qeap_back #(
    parameter int SEGMENTS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  qeap_pkg::desc_t   desc,
    input  logic              desc_empty,
    output logic              desc_pop,
    output qeap_pkg::point_t  point,
    output logic              point_push,
    input  logic              point_full
);

    localparam int W  = qeap_pkg::COORD_W;
    localparam int F  = qeap_pkg::FRAC_W;
    localparam int NW = $clog2(SEGMENTS + 1);

    // Series evaluation of cos and sin in Q30 for angle index n, packed {cos, sin}.
    function automatic logic [2*W-1:0] trig_entry(input int n);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        st;
        logic [63:0]        ct;
        logic signed [63:0] ssum;
        logic signed [63:0] csum;
        logic [W-1:0]       cq;
        logic [W-1:0]       sq;
        x    = (qeap_pkg::HALF_PI_Q30 * 64'(n)) / SEGMENTS;
        x2   = (x * x) >> F;
        st   = x;
        ct   = qeap_pkg::Q_ONE;
        ssum = signed'(x);
        csum = signed'(qeap_pkg::Q_ONE);
        for (int k = 0; k < 8; k++)
        begin
            st = ((st * x2) >> F) / qeap_pkg::SIN_DIV[k];
            ct = ((ct * x2) >> F) / qeap_pkg::COS_DIV[k];
            if ((k % 2) == 0)
            begin
                ssum = ssum - signed'(st);
                csum = csum - signed'(ct);
            end
            else
            begin
                ssum = ssum + signed'(st);
                csum = csum + signed'(ct);
            end
        end
        if (csum < 0)
            cq = '0;
        else if (csum > signed'(qeap_pkg::Q_ONE))
            cq = W'(qeap_pkg::Q_ONE);
        else
            cq = W'(csum);
        if (ssum < 0)
            sq = '0;
        else if (ssum > signed'(qeap_pkg::Q_ONE))
            sq = W'(qeap_pkg::Q_ONE);
        else
            sq = W'(ssum);
        return {cq, sq};
    endfunction

    logic [2*W-1:0] trig_tab [SEGMENTS+1];

    for (genvar g = 0; g <= SEGMENTS; g++)
    begin : g_tab
        localparam logic [2*W-1:0] ENTRY = trig_entry(g);
        assign trig_tab[g] = ENTRY;
    end

    logic [NW-1:0]         n_reg, n_next;
    logic                  a_valid_reg, a_valid_next;
    logic                  a_interior_reg;
    logic                  a_last_reg;
    logic signed [W-1:0]   a_ptx_reg, a_pty_reg;
    logic signed [W-1:0]   a_xo_reg, a_yo_reg;
    logic [2*W-1:0]        prod_c_reg, prod_s_reg;
    logic                  a_neg_reg, s_neg_reg, swap_reg;

    logic                  stage_free;
    logic                  go;
    logic                  is_first;
    logic                  is_last;
    logic [W-1:0]          cq, sq;
    logic [2*W-1:0]        rnd_c, rnd_s;
    logic [W:0]            term_c, term_s;
    logic [W:0]            sum_x, sum_y;

    always_comb
    begin
        stage_free = !a_valid_reg || !point_full;
        go         = !desc_empty && stage_free;
        is_first   = (n_reg == '0);
        is_last    = desc.arc ? (n_reg == NW'(SEGMENTS)) : (n_reg == NW'(1));
        desc_pop   = go && is_last;
        {cq, sq}   = trig_tab[n_reg];

        if (go)
            n_next = is_last ? '0 : n_reg + NW'(1);
        else
            n_next = n_reg;

        a_valid_next = stage_free ? go : a_valid_reg;

        // Round to nearest with halves away from zero, then apply the sign.
        rnd_c  = prod_c_reg + ((2*W)'(1) << (F - 1));
        rnd_s  = prod_s_reg + ((2*W)'(1) << (F - 1));
        term_c = a_neg_reg ? (W+1)'(-rnd_c[F+W:F]) : rnd_c[F+W:F];
        term_s = s_neg_reg ? (W+1)'(-rnd_s[F+W:F]) : rnd_s[F+W:F];
        sum_x  = (W+1)'(a_xo_reg) + (swap_reg ? term_s : term_c);
        sum_y  = (W+1)'(a_yo_reg) + (swap_reg ? term_c : term_s);

        point_push = a_valid_reg && !point_full;
        point.x    = a_interior_reg ? sum_x[W-1:0] : a_ptx_reg;
        point.y    = a_interior_reg ? sum_y[W-1:0] : a_pty_reg;
        point.last = a_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg       <= n_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_interior_reg <= !is_first && !is_last;
            a_last_reg     <= is_last;
            a_ptx_reg      <= is_first ? desc.xs : desc.xe;
            a_pty_reg      <= is_first ? desc.ys : desc.ye;
            a_xo_reg       <= desc.xo;
            a_yo_reg       <= desc.yo;
            prod_c_reg     <= (2*W)'(desc.a_mag) * (2*W)'(cq);
            prod_s_reg     <= (2*W)'(desc.r_mag) * (2*W)'(sq);
            a_neg_reg      <= desc.a_neg;
            s_neg_reg      <= desc.s_neg;
            swap_reg       <= desc.swap;
        end
    end

endmodule

@@ hw/rtl/quarter_ellipse_arc_points.sv @@
// Top level of the quarter ellipse arc point generator.
// Depends on qeap_pkg, qeap_front, qeap_fifo and qeap_back.
//
// Each segment beat on the input queue becomes a run of point beats on the result
// queue: two points for a straight segment or a degenerate arc, SEGMENTS+1 points
// for a quarter ellipse arc, the last one flagged by last_point. Points leave at
// one per cycle while a segment is queued and the result queue is not full; a
// segment is walked by the back end's single point walker with its pair of
// 31 by 31 bit multipliers. A two-entry segment queue lets new segments be taken
// while the previous one is still being walked, and the first point of a segment
// reaches the result queue through the back end's registered output stage.
module quarter_ellipse_arc_points #(
    parameter int SEGMENTS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [qeap_pkg::COORD_W-1:0] x_start,
    input  logic signed [qeap_pkg::COORD_W-1:0] y_start,
    input  logic signed [qeap_pkg::COORD_W-1:0] x_end,
    input  logic signed [qeap_pkg::COORD_W-1:0] y_end,
    input  logic        [1:0]                   func,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [qeap_pkg::COORD_W-1:0] x_point,
    output logic signed [qeap_pkg::COORD_W-1:0] y_point,
    output logic                                last_point
);

    qeap_pkg::desc_t  front_desc;
    qeap_pkg::desc_t  back_desc;
    logic             desc_empty;
    logic             desc_pop;
    qeap_pkg::point_t back_point;
    qeap_pkg::point_t out_point;
    logic             point_push;
    logic             point_full;

    qeap_front u_front (
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .func    (func),
        .desc    (front_desc)
    );

    qeap_fifo #(
        .WIDTH ($bits(qeap_pkg::desc_t)),
        .DEPTH (2)
    ) u_desc_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_desc),
        .full  (full),
        .pop   (desc_pop),
        .rdata (back_desc),
        .empty (desc_empty)
    );

    qeap_back #(
        .SEGMENTS (SEGMENTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (back_desc),
        .desc_empty (desc_empty),
        .desc_pop   (desc_pop),
        .point      (back_point),
        .point_push (point_push),
        .point_full (point_full)
    );

    qeap_fifo #(
        .WIDTH ($bits(qeap_pkg::point_t)),
        .DEPTH (2)
    ) u_point_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (point_push),
        .wdata (back_point),
        .full  (point_full),
        .pop   (pop),
        .rdata (out_point),
        .empty (empty)
    );

    assign x_point    = out_point.x;
    assign y_point    = out_point.y;
    assign last_point = out_point.last;

endmodule
